// ===== rtl/tccs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants for the text console engine: transaction
// payload structs, operation codes and character constants.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // character codes
  localparam logic [7:0] LINE_FEED       = 8'h0A;
  localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
  localparam logic [7:0] BLANK_CHAR      = 8'h20;

  // attribute after reset (white on black)
  localparam logic [7:0] RESET_ATTR = 8'h0F;

  // operation codes
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_BACK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // input transaction
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  char_code;
    logic        use_alternate;
    logic [7:0]  alternate_attribute;
    logic [10:0] cell_index;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] read_data;
    logic        scrolled;
  } out_item_t;

  // cell word: attribute in the high byte, character in the low byte
  function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
    make_cell = {attr, ch};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/text_console_cursor_scroll_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Text console engine: ROWS x COLUMNS cell store with cursor, wrap,
// scrolling, backspace, clear and cell read.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command transaction (mode, char,
//   attribute override, cell index). Every command yields exactly one result
//   transaction on out_valid/out_ready/out_data (cursor after the command,
//   read data, scroll flag). cfg_valid/cfg_data write the colour register;
//   cfg_ready is always high.
//   A scroll writes a blank to each cell of the new bottom row in turn (one
//   RAM write port); a clear rewrites every cell. One command is in flight
//   at a time; the next is taken in S_IDLE, which the engine enters again
//   as the result register loads.
//   Scrolling is a row ring: a base address rotates by one row, so only the
//   new bottom row is rewritten.
//   Reset: the cursor homes and a fill pass writes blank white-on-black to
//   all ROWS*COLUMNS cells, with in_ready low.
//   Stall: the result sits in an output register; the next command is taken
//   while it waits, and its own result holds in the engine until the output
//   register frees up.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tccs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tccs_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);

  import tccs_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int WIDE_W     = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_CALC  = 8'b0000_0100,
    S_ADDR  = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_SWEEP = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [7:0]        text_attribute;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] top_base;
  logic [ADDR_W-1:0] addr;
  logic              idx_ok;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_end;
  logic [15:0]       read_data;
  logic              scrolled;

  // latched command
  mode_t             cmd_mode;
  logic [7:0]        cmd_char;
  logic [7:0]        cmd_attr;
  logic [10:0]       cmd_index;

  // RAM port signals
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [15:0]       mem_rdata;

  // address arithmetic
  logic [WIDE_W-1:0] idx_wide;
  logic [WIDE_W-1:0] lin_cur;
  logic [WIDE_W-1:0] phys_sum;
  logic [WIDE_W-1:0] phys_wrap;
  logic [31:0]       row_ext;
  logic [31:0]       col_ext;
  logic              at_bottom;
  logic              at_last_col;
  logic              out_free;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign at_bottom   = (row == ROW_W'(ROWS - 1));
  assign at_last_col = (col == COL_W'(COLUMNS - 1));
  assign out_free    = !out_valid || out_ready;

  // logical to physical address through the row ring
  always_comb begin
    idx_wide  = WIDE_W'(cmd_index);
    lin_cur   = WIDE_W'(row) * WIDE_W'(COLUMNS) + WIDE_W'(col);
    phys_sum  = ((cmd_mode == MODE_READ) ? idx_wide : lin_cur) + WIDE_W'(top_base);
    phys_wrap = (phys_sum >= WIDE_W'(CELL_COUNT)) ? (phys_sum - WIDE_W'(CELL_COUNT))
                                                  : phys_sum;
  end

  // colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      text_attribute <= cfg_data;
    end
  end

  // RAM controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = make_cell(BLANK_CHAR, cmd_attr);
    mem_re    = 1'b0;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = make_cell(BLANK_CHAR, RESET_ATTR);
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
      end
      S_EXEC: begin
        unique case (cmd_mode)
          MODE_PUT: begin
            mem_we    = (cmd_char != LINE_FEED) && (cmd_char != CARRIAGE_RETURN);
            mem_wdata = make_cell(cmd_char, cmd_attr);
          end
          MODE_BACK:  mem_we = 1'b1;
          MODE_CLEAR: mem_we = 1'b0;
          MODE_READ:  mem_re = idx_ok;
        endcase
      end
      S_IDLE, S_CALC, S_ADDR, S_READ, S_RESP: begin
        mem_we = 1'b0;
      end
    endcase
  end

  tccs_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      row        <= '0;
      col        <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      sweep_end  <= ADDR_W'(CELL_COUNT - 1);
      scrolled   <= 1'b0;
      read_data  <= '0;
    end else begin
      unique case (state)
        // power-up fill of every cell
        S_INIT: begin
          if (sweep_addr == sweep_end) begin
            state <= S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_mode  <= in_data.mode;
            cmd_char  <= in_data.char_code;
            cmd_attr  <= in_data.use_alternate ? in_data.alternate_attribute
                                               : text_attribute;
            cmd_index <= in_data.cell_index;
            scrolled  <= 1'b0;
            read_data <= '0;
            state     <= S_CALC;
          end
        end
        // backspace moves the cursor before the blank write
        S_CALC: begin
          if (cmd_mode == MODE_BACK) begin
            if (col != '0) begin
              col <= col - 1'b1;
            end else if (row != '0) begin
              row <= row - 1'b1;
              col <= COL_W'(COLUMNS - 1);
            end
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr   <= phys_wrap[ADDR_W-1:0];
          idx_ok <= idx_wide < WIDE_W'(CELL_COUNT);
          state  <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_RESP;
          unique case (cmd_mode)
            MODE_PUT: begin
              if (cmd_char == CARRIAGE_RETURN) begin
                col <= '0;
              end else if ((cmd_char == LINE_FEED) || at_last_col) begin
                col <= '0;
                if (at_bottom) begin
                  // scroll: old top row becomes the new bottom row
                  scrolled   <= 1'b1;
                  sweep_addr <= top_base;
                  sweep_end  <= top_base + ADDR_W'(COLUMNS - 1);
                  top_base   <= (top_base == ADDR_W'(CELL_COUNT - COLUMNS))
                                ? '0 : top_base + ADDR_W'(COLUMNS);
                  state      <= S_SWEEP;
                end else begin
                  row <= row + 1'b1;
                end
              end else begin
                col <= col + 1'b1;
              end
            end
            MODE_BACK: begin
              state <= S_RESP;
            end
            MODE_CLEAR: begin
              row        <= '0;
              col        <= '0;
              top_base   <= '0;
              sweep_addr <= '0;
              sweep_end  <= ADDR_W'(CELL_COUNT - 1);
              state      <= S_SWEEP;
            end
            MODE_READ: begin
              if (idx_ok) begin
                state <= S_READ;
              end
            end
          endcase
        end
        // blank a row (scroll) or the whole store (clear)
        S_SWEEP: begin
          if (sweep_addr == sweep_end) begin
            state <= S_RESP;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_READ: begin
          read_data <= mem_rdata;
          state     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // result register
  always_comb begin
    row_ext = 32'(row);
    col_ext = 32'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      out_data.cursor_row <= row_ext[4:0];
      out_data.cursor_col <= col_ext[6:0];
      out_data.read_data  <= read_data;
      out_data.scrolled   <= scrolled;
    end
  end

`ifndef SYNTH
  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(row) < ROWS) && (32'(col) < COLUMNS))
    else $error("cursor outside the screen");

  // ring base is always row aligned within the store
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    32'(top_base) <= CELL_COUNT - COLUMNS)
    else $error("row ring base out of range");

  // every cell write lands inside the store
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < CELL_COUNT))
    else $error("cell write out of range");

  // a sweep never runs past its end address
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SWEEP) || (state == S_INIT)) |-> (sweep_addr <= sweep_end))
    else $error("sweep overran its end");

  // a scroll always goes through the row blanking sweep
  a_scroll_sweep: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && (cmd_mode == MODE_PUT) && (cmd_char != CARRIAGE_RETURN) &&
     ((cmd_char == LINE_FEED) || at_last_col) && at_bottom) |=> (state == S_SWEEP))
    else $error("scroll without row blanking");
`endif

endmodule
`default_nettype wire

// ===== rtl/tccs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
